// File: rtl/core/atc_pkg.sv
package atc_pkg;

   localparam int MAX_ENTRIES = 64;
   localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
   localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
   localparam int WORD_W = 32;

   typedef enum logic [1:0] {
      OP_ALLOC = 2'd0,
      OP_FREE  = 2'd1,
      OP_END   = 2'd2,
      OP_NONE  = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_LEN_MISMATCH = 2'd0,
      ST_NOT_ALLOC    = 2'd1,
      ST_TABLE_FULL   = 2'd2,
      ST_LEAK         = 2'd3
   } status_type;

   typedef struct packed {
      logic wr;
      logic step;
      logic flush;
      logic clr;
   } cell_ctl_type;

   typedef struct packed {
      logic              tok;
      logic              live;
      logic              hit;
      logic [WORD_W-1:0] addr;
      logic [WORD_W-1:0] len;
   } cell_stat_type;

endpackage

// File: rtl/core/atc_if.sv
interface atc_req_if;
   import atc_pkg::*;
   logic              valid;
   logic              ready;
   logic [1:0]        op;
   logic [WORD_W-1:0] block_addr;
   logic [WORD_W-1:0] block_len;
   modport source (output valid, op, block_addr, block_len, input ready);
   modport sink (input valid, op, block_addr, block_len, output ready);
endinterface

interface atc_rsp_if;
   import atc_pkg::*;
   logic              valid;
   logic              ready;
   logic [1:0]        status;
   logic [WORD_W-1:0] position;
   logic [WORD_W-1:0] found_addr;
   logic [WORD_W-1:0] alloc_len;
   logic [WORD_W-1:0] free_len;
   logic              last;
   modport source (output valid, status, position, found_addr, alloc_len, free_len, last,
                   input ready);
   modport sink (input valid, status, position, found_addr, alloc_len, free_len, last,
                 output ready);
endinterface

// File: rtl/core/atc_cell.sv
module atc_cell (
   input  logic                          clock,
   input  logic                          reset,
   input  atc_pkg::cell_ctl_type         ctl,
   input  logic [atc_pkg::WORD_W-1:0]    q_addr,
   input  logic [atc_pkg::WORD_W-1:0]    q_len,
   input  logic                          tok_in,
   output logic                          tok_out,
   output atc_pkg::cell_stat_type        stat
);
   import atc_pkg::*;

   logic [WORD_W-1:0] addr_ff, addr_in;
   logic [WORD_W-1:0] len_ff, len_in;
   logic              live_ff, live_in;
   logic              tok_ff, tok_in_nxt;

   always_comb begin
      addr_in = ctl.wr ? q_addr : addr_ff;
      len_in = ctl.wr ? q_len : len_ff;
      live_in = live_ff;
      if (ctl.wr) begin
         live_in = 1'b1;
      end else if (ctl.clr && tok_ff) begin
         live_in = 1'b0;
      end
      // token moves one cell per step; flush drops it after an early stop
      tok_in_nxt = ctl.flush ? 1'b0 : (ctl.step ? tok_in : tok_ff);
   end

   always_ff @(posedge clock) begin
      addr_ff <= addr_in;
      len_ff <= len_in;
      if (reset) begin
         live_ff <= 1'b0;
         tok_ff <= 1'b0;
      end else begin
         live_ff <= live_in;
         tok_ff <= tok_in_nxt;
      end
   end

   assign tok_out = tok_ff;
   assign stat.tok = tok_ff;
   assign stat.live = live_ff;
   assign stat.hit = tok_ff && live_ff && (addr_ff == q_addr);
   assign stat.addr = tok_ff ? addr_ff : '0;
   assign stat.len = tok_ff ? len_ff : '0;

endmodule

// File: rtl/core/allocation_trace_checker.sv
// Allocation trace checker. Allocs append to a row of MAX_ENTRIES cells; a
// table-full alloc answers at once. A free, or an end-of-trace item while any
// cell is live, sends a token down the cell row, one cell per cycle while the
// output is not stalled: a free stops at the first live matching cell, the
// report visits every cell up to the last live one and gives one leak transfer
// per live cell. The walk pauses while a result waits on a stalled output, and
// no new item is taken until the walk is done.
module allocation_trace_checker (
   input logic clock,
   input logic reset,
   atc_req_if.sink   req,
   atc_rsp_if.source rsp
);
   import atc_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE = 3'b001,
      S_FREE = 3'b010,
      S_LEAK = 3'b100
   } state_type;

   state_type state_ff, state_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [WORD_W-1:0] rec_ff, rec_in;
   logic [IDX_W-1:0]  pos_ff, pos_in;
   logic [WORD_W-1:0] q_addr_ff, q_addr_in;
   logic [WORD_W-1:0] q_len_ff, q_len_in;

   logic              rv_ff, rv_in;
   logic [1:0]        rs_ff, rs_in;
   logic [WORD_W-1:0] rp_ff, rp_in, ra_ff, ra_in, ral_ff, ral_in, rfl_ff, rfl_in;
   logic              rl_ff, rl_in;

   cell_ctl_type  ctl [MAX_ENTRIES];
   cell_stat_type stat [MAX_ENTRIES];
   logic [MAX_ENTRIES:0] tok_chain;
   logic [MAX_ENTRIES-1:0] live_vec, tok_vec, hit_vec, after_vec;
   logic [WORD_W-1:0] sel_addr, sel_len;
   logic out_free, accept, start, step, flush, clr, tok_live, any_hit, later, at_end;
   logic [WORD_W-1:0] rec_next;
   logic [WORD_W-1:0] in_addr, in_len;

   assign out_free = !rv_ff || rsp.ready;
   assign req.ready = (state_ff == S_IDLE) && out_free;
   assign accept = req.valid && req.ready;
   assign rec_next = rec_ff + 32'd1;
   assign in_addr = (state_ff == S_IDLE) ? req.block_addr : q_addr_ff;
   assign in_len = (state_ff == S_IDLE) ? req.block_len : q_len_ff;

   always_comb begin
      sel_addr = '0;
      sel_len = '0;
      for (int i = 0; i < MAX_ENTRIES; i++) begin
         live_vec[i] = stat[i].live;
         tok_vec[i] = stat[i].tok;
         hit_vec[i] = stat[i].hit;
         sel_addr = sel_addr | stat[i].addr;
         sel_len = sel_len | stat[i].len;
      end
   end

   assign any_hit = |hit_vec;
   assign tok_live = |(tok_vec & live_vec);
   assign after_vec = live_vec >> pos_ff;
   assign later = |(after_vec >> 1);
   assign at_end = (pos_ff == IDX_W'(MAX_ENTRIES - 1));

   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      rec_in = rec_ff;
      pos_in = pos_ff;
      q_addr_in = q_addr_ff;
      q_len_in = q_len_ff;
      rv_in = rv_ff && !rsp.ready;
      rs_in = rs_ff;
      rp_in = rp_ff;
      ra_in = ra_ff;
      ral_in = ral_ff;
      rfl_in = rfl_ff;
      rl_in = rl_ff;
      start = 1'b0;
      step = 1'b0;
      flush = 1'b0;
      clr = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               q_addr_in = req.block_addr;
               q_len_in = req.block_len;
               pos_in = '0;
               unique case (op_type'(req.op))
                  OP_ALLOC: begin
                     rec_in = rec_next;
                     if (count_ff == CNT_W'(MAX_ENTRIES)) begin
                        rv_in = 1'b1;
                        rs_in = ST_TABLE_FULL;
                        rp_in = rec_next;
                        ra_in = req.block_addr;
                        ral_in = '0;
                        rfl_in = '0;
                        rl_in = 1'b1;
                     end else begin
                        count_in = count_ff + CNT_W'(1);
                     end
                  end
                  OP_FREE: begin
                     rec_in = rec_next;
                     start = 1'b1;
                     state_in = S_FREE;
                  end
                  OP_END: begin
                     if (|live_vec) begin
                        start = 1'b1;
                        state_in = S_LEAK;
                     end
                  end
                  OP_NONE: ;
                  default: ;
               endcase
            end
         end
         S_FREE: begin
            if (out_free) begin
               if (any_hit) begin
                  clr = 1'b1;
                  flush = 1'b1;
                  state_in = S_IDLE;
                  if (sel_len != q_len_ff) begin
                     rv_in = 1'b1;
                     rs_in = ST_LEN_MISMATCH;
                     rp_in = rec_ff;
                     ra_in = q_addr_ff;
                     ral_in = sel_len;
                     rfl_in = q_len_ff;
                     rl_in = 1'b1;
                  end
               end else if (at_end) begin
                  step = 1'b1;
                  state_in = S_IDLE;
                  rv_in = 1'b1;
                  rs_in = ST_NOT_ALLOC;
                  rp_in = rec_ff;
                  ra_in = q_addr_ff;
                  ral_in = '0;
                  rfl_in = q_len_ff;
                  rl_in = 1'b1;
               end else begin
                  step = 1'b1;
                  pos_in = pos_ff + IDX_W'(1);
               end
            end
         end
         S_LEAK: begin
            if (out_free) begin
               if (tok_live) begin
                  rv_in = 1'b1;
                  rs_in = ST_LEAK;
                  rp_in = WORD_W'(pos_ff);
                  ra_in = sel_addr;
                  ral_in = sel_len;
                  rfl_in = '0;
                  rl_in = !later;
               end
               if ((tok_live && !later) || at_end) begin
                  flush = 1'b1;
                  state_in = S_IDLE;
               end else begin
                  step = 1'b1;
                  pos_in = pos_ff + IDX_W'(1);
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   assign tok_chain[0] = start;

   for (genvar g = 0; g < MAX_ENTRIES; g++) begin : g_cell
      always_comb begin
         ctl[g].wr = accept && (op_type'(req.op) == OP_ALLOC)
                     && (count_ff == CNT_W'(g));
         ctl[g].step = step || start;
         ctl[g].flush = flush;
         ctl[g].clr = clr;
      end
      atc_cell u_cell (
         .clock   (clock),
         .reset   (reset),
         .ctl     (ctl[g]),
         .q_addr  (in_addr),
         .q_len   (in_len),
         .tok_in  (tok_chain[g]),
         .tok_out (tok_chain[g+1]),
         .stat    (stat[g])
      );
   end

   always_ff @(posedge clock) begin
      q_addr_ff <= q_addr_in;
      q_len_ff <= q_len_in;
      pos_ff <= pos_in;
      rs_ff <= rs_in;
      rp_ff <= rp_in;
      ra_ff <= ra_in;
      ral_ff <= ral_in;
      rfl_ff <= rfl_in;
      rl_ff <= rl_in;
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
         rec_ff <= '0;
         rv_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         rec_ff <= rec_in;
         rv_ff <= rv_in;
      end
   end

   assign rsp.valid = rv_ff;
   assign rsp.status = rs_ff;
   assign rsp.position = rp_ff;
   assign rsp.found_addr = ra_ff;
   assign rsp.alloc_len = ral_ff;
   assign rsp.free_len = rfl_ff;
   assign rsp.last = rl_ff;

endmodule
